// ===== design/semu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// semu_pkg
// Shared types, status codes and sizes for the counting semaphore unit.
// ----------------------------------------------------------------------------
package semu_pkg;

   localparam int WAITER_SLOTS_DEF = 16;
   localparam int RESULT_LIMIT     = 16;
   localparam int WAKE_W           = $clog2(RESULT_LIMIT + 1);

   localparam logic [2:0] STATUS_GRANTED = 3'd0;
   localparam logic [2:0] STATUS_BLOCKED = 3'd1;
   localparam logic [2:0] STATUS_WOKEN   = 3'd2;
   localparam logic [2:0] STATUS_NOWAKE  = 3'd3;
   localparam logic [2:0] STATUS_FULL    = 3'd4;

   localparam logic OP_WAIT   = 1'b0;
   localparam logic OP_SIGNAL = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [15:0] pid;
      logic [15:0] need;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } sm_state_type;

endpackage

`default_nettype wire

// ===== design/semu_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// semu_cell
// One waiter slot of the rotating table; hands its entry to the next cell
// on every shift.
// ----------------------------------------------------------------------------
module semu_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                shift_en,
   input  wire semu_pkg::entry_type entry_in,
   output semu_pkg::entry_type      entry_out
);

   logic        valid_ff;
   logic [15:0] pid_ff;
   logic [15:0] need_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pid_ff  <= entry_in.pid;
         need_ff <= entry_in.need;
      end
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.pid   = pid_ff;
   assign entry_out.need  = need_ff;

endmodule

`default_nettype wire

// ===== design/semu_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// semu_ctrl
// Request sequencer: grants waits, rotates the waiter ring once per blocked
// wait or signal, and emits result beats.
// ----------------------------------------------------------------------------
module semu_ctrl #(
   parameter int WAITER_SLOTS = semu_pkg::WAITER_SLOTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [15:0]         req_proc_id,
   input  wire logic [15:0]         req_amount,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [15:0]              rsp_woken_id,
   output logic [31:0]              rsp_count_now,
   output logic                     rsp_last,
   input  wire semu_pkg::entry_type head_entry,
   output semu_pkg::entry_type      tail_entry,
   output logic                     shift_en
);

   localparam int STEP_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam int WAKE_W = semu_pkg::WAKE_W;

   semu_pkg::sm_state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              op_ff, op_in;
   logic [15:0]       pid_ff, pid_in;
   logic [15:0]       need_ff, need_in;
   logic [31:0]       count_ff, count_in;
   logic [WAKE_W-1:0] wake_cnt_ff, wake_cnt_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [15:0]       pend_pid_ff, pend_pid_in;
   logic              ins_done_ff, ins_done_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [15:0]       rsp_pid_ff, rsp_pid_in;
   logic [31:0]       rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              req_fire;
   logic [15:0]       req_need;
   logic [32:0]       sum;
   logic [31:0]       sig_count;
   logic              grant;
   logic              match;
   logic              advance;
   logic              scan_end;
   logic              emit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == semu_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign req_need  = (req_amount == 16'd0) ? 16'd1 : req_amount;
   assign sum       = {1'b0, count_ff} + {17'd0, req_amount};
   assign sig_count = (req_amount == 16'd0) ? 32'd1 :
                      (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
   assign grant     = (count_ff >= {16'd0, req_need});
   assign match     = (op_ff == semu_pkg::OP_SIGNAL) && head_entry.valid &&
                      ({16'd0, head_entry.need} <= count_ff) &&
                      (wake_cnt_ff < WAKE_W'(semu_pkg::RESULT_LIMIT));
   assign advance   = !(match && pend_valid_ff) || out_free;
   assign scan_end  = (step_ff == STEP_W'(WAITER_SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         semu_pkg::ST_IDLE: begin
            if (req_fire && !(req_opcode == semu_pkg::OP_WAIT && grant)) begin
               state_in = semu_pkg::ST_SCAN;
            end
         end
         semu_pkg::ST_SCAN: begin
            if (advance && scan_end) begin
               state_in = semu_pkg::ST_DONE;
            end
         end
         semu_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = semu_pkg::ST_IDLE;
            end
         end
         default: state_in = semu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step_in       = step_ff;
      op_in         = op_ff;
      pid_in        = pid_ff;
      need_in       = need_ff;
      count_in      = count_ff;
      wake_cnt_in   = wake_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_pid_in   = pend_pid_ff;
      ins_done_in   = ins_done_ff;
      tail_entry    = head_entry;
      shift_en      = 1'b0;
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         semu_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_opcode;
               pid_in        = req_proc_id;
               need_in       = req_need;
               step_in       = '0;
               wake_cnt_in   = '0;
               pend_valid_in = 1'b0;
               ins_done_in   = 1'b0;
               if (req_opcode == semu_pkg::OP_WAIT) begin
                  if (grant) begin
                     count_in      = count_ff - {16'd0, req_need};
                     emit          = 1'b1;
                     rsp_status_in = semu_pkg::STATUS_GRANTED;
                     rsp_pid_in    = req_proc_id;
                     rsp_count_in  = count_ff - {16'd0, req_need};
                     rsp_last_in   = 1'b1;
                  end
               end else begin
                  count_in = sig_count;
               end
            end
         end
         semu_pkg::ST_SCAN: begin
            if (advance) begin
               shift_en = 1'b1;
               step_in  = step_ff + 1'b1;
               if (op_ff == semu_pkg::OP_WAIT) begin
                  if (!head_entry.valid && !ins_done_ff) begin
                     tail_entry.valid = 1'b1;
                     tail_entry.pid   = pid_ff;
                     tail_entry.need  = need_ff;
                     ins_done_in      = 1'b1;
                  end
               end else if (match) begin
                  tail_entry.valid = 1'b0;
                  wake_cnt_in      = wake_cnt_ff + 1'b1;
                  pend_valid_in    = 1'b1;
                  pend_pid_in      = head_entry.pid;
                  if (pend_valid_ff) begin
                     emit          = 1'b1;
                     rsp_status_in = semu_pkg::STATUS_WOKEN;
                     rsp_pid_in    = pend_pid_ff;
                     rsp_count_in  = count_ff;
                     rsp_last_in   = 1'b0;
                  end
               end
            end
         end
         semu_pkg::ST_DONE: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_count_in = count_ff;
               rsp_last_in  = 1'b1;
               rsp_pid_in   = pid_ff;
               if (op_ff == semu_pkg::OP_WAIT) begin
                  rsp_status_in = ins_done_ff ? semu_pkg::STATUS_BLOCKED
                                              : semu_pkg::STATUS_FULL;
               end else if (pend_valid_ff) begin
                  rsp_status_in = semu_pkg::STATUS_WOKEN;
                  rsp_pid_in    = pend_pid_ff;
               end else begin
                  rsp_status_in = semu_pkg::STATUS_NOWAKE;
               end
            end
         end
         default: begin
            shift_en = 1'b0;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= semu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      need_ff       <= need_in;
      wake_cnt_ff   <= wake_cnt_in;
      pend_valid_ff <= pend_valid_in;
      pend_pid_ff   <= pend_pid_in;
      ins_done_ff   <= ins_done_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pid_ff    <= rsp_pid_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_woken_id  = rsp_pid_ff;
   assign rsp_count_now = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   a_wake_budget: assert property (@(posedge clock) disable iff (reset)
      (state_ff == semu_pkg::ST_SCAN) |->
         (wake_cnt_ff <= WAKE_W'(semu_pkg::RESULT_LIMIT)))
      else $error("wake budget exceeded");

   a_scan_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == semu_pkg::ST_SCAN && rsp_valid_ff) |->
         (rsp_status_ff == semu_pkg::STATUS_WOKEN && !rsp_last_ff))
      else $error("non-wake or final beat during scan");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == semu_pkg::ST_IDLE && state_in == semu_pkg::ST_SCAN) |=>
         (step_ff == '0 && !pend_valid_ff && !ins_done_ff))
      else $error("scan started with stale state");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != semu_pkg::ST_IDLE) |-> !req_ready)
      else $error("request accepted while busy");

endmodule

`default_nettype wire

// ===== design/counting_semaphore_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_unit
// Counting semaphore with a bounded waiter table held in a rotating ring.
// ----------------------------------------------------------------------------
// A wait that the count covers is granted without a ring rotation. A wait
// that blocks and every signal rotate the waiter ring once, one slot a cycle
// unless stalled on rsp_ready; a signal emits one woken beat per released
// waiter (at most 16, in slot order) or one no-wake beat, with rsp_last on
// the final beat. The ring of per-slot cells is the only table storage and
// its rotation sets the rate.
// ----------------------------------------------------------------------------
module counting_semaphore_unit #(
   parameter int WAITER_SLOTS = semu_pkg::WAITER_SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_proc_id,
   input  wire logic [15:0] req_amount,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_woken_id,
   output logic [31:0]      rsp_count_now,
   output logic             rsp_last
);

   semu_pkg::entry_type ring [WAITER_SLOTS];
   semu_pkg::entry_type tail_entry;
   logic                shift_en;

   semu_ctrl #(
      .WAITER_SLOTS(WAITER_SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_proc_id  (req_proc_id),
      .req_amount   (req_amount),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_woken_id (rsp_woken_id),
      .rsp_count_now(rsp_count_now),
      .rsp_last     (rsp_last),
      .head_entry   (ring[0]),
      .tail_entry   (tail_entry),
      .shift_en     (shift_en)
   );

   for (genvar k = 0; k < WAITER_SLOTS; k++) begin : g_cell
      semu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .entry_in ((k == WAITER_SLOTS - 1) ? tail_entry : ring[(k + 1) % WAITER_SLOTS]),
         .entry_out(ring[k])
      );
   end

endmodule

`default_nettype wire
